[src/rclm_pkg.sv]
// Package for the remote code learn/match table: sizes, codes, item and control types.
package rclm_pkg;

  localparam int ENTRIES    = 16;
  localparam int CODE_BITS  = 24;
  localparam int CTRL_SHIFT = 4;
  localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int USED_W     = $clog2(ENTRIES + 1);
  localparam int USED_MAX   = 31;

  localparam logic [2:0] ACT_CODE   = 3'd0;
  localparam logic [2:0] ACT_START  = 3'd1;
  localparam logic [2:0] ACT_EXIT   = 3'd2;
  localparam logic [2:0] ACT_DELETE = 3'd3;
  localparam logic [2:0] ACT_TICK   = 3'd4;

  localparam logic [2:0] RPT_NONE    = 3'd0;
  localparam logic [2:0] RPT_MATCH   = 3'd1;
  localparam logic [2:0] RPT_LEARNED = 3'd2;
  localparam logic [2:0] RPT_EXISTS  = 3'd3;
  localparam logic [2:0] RPT_FULL    = 3'd4;
  localparam logic [2:0] RPT_TIMEOUT = 3'd5;

  localparam logic [1:0] KIND_ALARM   = 2'd0;
  localparam logic [1:0] KIND_CONTROL = 2'd1;

  localparam logic [7:0] TIMEOUT_RESET = 8'd30;

  typedef logic [CODE_BITS-1:0] code_t;
  typedef logic [IDX_W-1:0]     idx_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [23:0] rx_code;
    logic [1:0]  learn_type;
    logic [3:0]  entry_select;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  report;
    logic [3:0]  hit_index;
    logic [1:0]  hit_type;
    logic [23:0] echo_code;
    logic [4:0]  used_entries;
    logic        learning;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic is_code;
    logic scan_last;
    logic out_free;
  } dp_status_t;

  function automatic logic entry_hit(logic [1:0] kind, code_t stored, code_t code);
    logic hit;
    hit = 1'b0;
    if (kind == KIND_CONTROL) begin
      hit = (stored[CODE_BITS-1:CTRL_SHIFT] == code[CODE_BITS-1:CTRL_SHIFT]);
    end else if (kind == KIND_ALARM) begin
      hit = (stored == code);
    end
    return hit;
  endfunction

endpackage

[src/rclm_ctrl.sv]
// Controller state machine: accept, table scan, drain and result write-back.
module rclm_ctrl import rclm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (status_i.is_code) begin
            cmd_o.scan_start = 1'b1;
            state_d          = ST_SCAN;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[src/rclm_dp.sv]
// Datapath: entry table, scan registers, learn state and output register.
module rclm_dp import rclm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  in_item_t   in_data_i,
  input  logic       out_stall_i,
  output logic       out_valid_o,
  output out_item_t  out_data_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  dp_cmd_t    cmd_i,
  output dp_status_t status_o
);

  code_t      mem_code [ENTRIES];
  logic [1:0] mem_kind [ENTRIES];

  in_item_t    item_q;
  idx_t        cnt_q;
  logic        rd_vld_q;
  idx_t        rd_idx_q;
  code_t       rd_code_q;
  logic [1:0]  rd_kind_q;

  logic        match_found_q;
  idx_t        match_idx_q;
  logic [1:0]  match_kind_q;
  logic        free_found_q;
  idx_t        free_idx_q;

  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [USED_W-1:0]  used_q, used_d;
  logic               learn_q, learn_d;
  logic [1:0]         pending_q, pending_d;
  logic [7:0]         elapsed_q, elapsed_d;
  logic [7:0]         timeout_q;

  logic       out_valid_q;
  out_item_t  out_q, res;
  logic       wr_en;
  code_t      code_in;
  idx_t       sel_idx;

  assign code_in = CODE_BITS'(item_q.rx_code);
  assign sel_idx = IDX_W'(item_q.entry_select);

  assign status_o.is_code   = (in_data_i.action == ACT_CODE);
  assign status_o.scan_last = (cnt_q == IDX_W'(ENTRIES - 1));
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
    end
    if (wr_en) begin
      mem_code[free_idx_q] <= code_in;
      mem_kind[free_idx_q] <= pending_q;
    end
    rd_code_q <= mem_code[cnt_q];
    rd_kind_q <= mem_kind[cnt_q];
    rd_idx_q  <= cnt_q;
    if (cmd_i.finish) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q         <= '0;
      rd_vld_q      <= 1'b0;
      match_found_q <= 1'b0;
      match_idx_q   <= '0;
      match_kind_q  <= '0;
      free_found_q  <= 1'b0;
      free_idx_q    <= '0;
    end else begin
      rd_vld_q <= cmd_i.scan_step;
      if (cmd_i.scan_start) begin
        cnt_q         <= '0;
        match_found_q <= 1'b0;
        free_found_q  <= 1'b0;
      end else begin
        if (cmd_i.scan_step && !status_o.scan_last) begin
          cnt_q <= cnt_q + 1'b1;
        end
        if (rd_vld_q) begin
          if (valid_q[rd_idx_q] && !match_found_q &&
              entry_hit(rd_kind_q, rd_code_q, code_in)) begin
            match_found_q <= 1'b1;
            match_idx_q   <= rd_idx_q;
            match_kind_q  <= rd_kind_q;
          end
          if (!valid_q[rd_idx_q] && !free_found_q) begin
            free_found_q <= 1'b1;
            free_idx_q   <= rd_idx_q;
          end
        end
      end
    end
  end

  always_comb begin
    valid_d   = valid_q;
    used_d    = used_q;
    learn_d   = learn_q;
    pending_d = pending_q;
    elapsed_d = elapsed_q;
    wr_en     = 1'b0;
    res       = '0;
    case (item_q.action)
      ACT_CODE: begin
        res.echo_code = 24'(code_in);
        if (!learn_q) begin
          if (match_found_q) begin
            res.report    = RPT_MATCH;
            res.hit_index = 4'(match_idx_q);
            res.hit_type  = match_kind_q;
          end
        end else begin
          if (!free_found_q) begin
            res.report = RPT_FULL;
          end else if (!match_found_q) begin
            wr_en              = cmd_i.finish;
            valid_d[free_idx_q] = 1'b1;
            used_d             = used_q + 1'b1;
            res.report         = RPT_LEARNED;
            res.hit_index      = 4'(free_idx_q);
            res.hit_type       = pending_q;
          end else begin
            res.report    = RPT_EXISTS;
            res.hit_index = 4'(match_idx_q);
            res.hit_type  = match_kind_q;
          end
          learn_d   = 1'b0;
          elapsed_d = '0;
        end
      end
      ACT_START: begin
        if (!learn_q) begin
          elapsed_d = '0;
        end
        learn_d   = 1'b1;
        pending_d = item_q.learn_type;
      end
      ACT_EXIT: begin
        learn_d   = 1'b0;
        elapsed_d = '0;
      end
      ACT_DELETE: begin
        if ((32'(item_q.entry_select) < ENTRIES) && valid_q[sel_idx]) begin
          valid_d[sel_idx] = 1'b0;
          used_d           = used_q - 1'b1;
        end
      end
      ACT_TICK: begin
        if (learn_q) begin
          if (elapsed_q >= timeout_q) begin
            res.report = RPT_TIMEOUT;
            learn_d    = 1'b0;
            elapsed_d  = '0;
          end else begin
            elapsed_d = elapsed_q + 8'd1;
          end
        end
      end
      default: begin
        res.report = RPT_NONE;
      end
    endcase
    res.used_entries = (32'(used_d) > USED_MAX) ? 5'(USED_MAX) : 5'(used_d);
    res.learning     = learn_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      used_q      <= '0;
      learn_q     <= 1'b0;
      pending_q   <= '0;
      elapsed_q   <= '0;
      timeout_q   <= TIMEOUT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      if (cmd_i.finish) begin
        valid_q     <= valid_d;
        used_q      <= used_d;
        learn_q     <= learn_d;
        pending_q   <= pending_d;
        elapsed_q   <= elapsed_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

[src/remote_code_learn_match_table.sv]
// Remote code learn/match table, top level.
// Received code: all 16 table entries are read through the single memory read port, then a drain
// and a finish step write back the registered result; no new transfer is accepted until the
// finish. Other actions go straight from acceptance to the finish step.
// A result stalled at the output holds the next item in its finish cycle.
// Reset clears all entries, leaves learn mode and sets the timeout to 30 seconds.
module remote_code_learn_match_table import rclm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_item_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_data_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);

  dp_cmd_t    cmd;
  dp_status_t status;

  rclm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rclm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule
